// ===== rtl/core/double_to_target_float_word_defines.svh =====
// Assertion macros used by the checker of the binary64 to target float word converter.
`ifndef DOUBLE_TO_TARGET_FLOAT_WORD_DEFINES_SVH
`define DOUBLE_TO_TARGET_FLOAT_WORD_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTFW_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("converter check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTFW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("converter check failed");

`endif

// ===== rtl/core/dtfw_pkg.sv =====
// Types and constants of the binary64 to target float word converter.
package dtfw_pkg;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned FRAC_W    = 52;
   localparam int unsigned EXP_IN_W  = 11;
   localparam int unsigned EXP_OUT_W = 11;
   localparam int unsigned HI_MANT_W = 20;

   localparam logic [EXP_IN_W-1:0]  EXP_IN_SPECIAL  = 11'h7FF;
   localparam logic [EXP_OUT_W-1:0] EXP_FIELD_MAX   = 11'h7FF;
   localparam logic [EXP_OUT_W:0]   EXP_NORMAL_BIAS = 12'd2;
   localparam logic [5:0]           SUB_LZ_LIMIT    = 6'd2;

   typedef struct packed {
      logic [WORD_W-1:0] word_high;
      logic [WORD_W-1:0] word_low;
      logic              range_error;
   } result_type;

endpackage

// ===== rtl/core/dtfw_req_if.sv =====
// Input channel carrying one binary64 bit pattern per beat.
interface dtfw_req_if;
   logic                           valid;
   logic                           ready;
   logic [dtfw_pkg::VALUE_W-1:0]   value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

// ===== rtl/core/dtfw_rsp_if.sv =====
// Result channel carrying one target float word and its range flag per beat.
interface dtfw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dtfw_pkg::WORD_W-1:0]   word_high;
   logic [dtfw_pkg::WORD_W-1:0]   word_low;
   logic                          range_error;

   modport source (output valid, output word_high, output word_low, output range_error,
                   input ready);
   modport sink (input valid, input word_high, input word_low, input range_error,
                 output ready);
endinterface

// ===== rtl/core/dtfw_norm.sv =====
// Combinational normalizer that forms the target float word from a binary64 pattern.
module dtfw_norm (
   input  logic [dtfw_pkg::VALUE_W-1:0] value_bits,
   output dtfw_pkg::result_type         result
);

   logic                              sign;
   logic [dtfw_pkg::EXP_IN_W-1:0]     ex;
   logic [dtfw_pkg::FRAC_W-1:0]       frac;
   logic [63:0]                       n0, n1, n2, n3, n4, n5, n6;
   logic [5:0]                        lz;
   logic [dtfw_pkg::EXP_OUT_W:0]      sum;
   logic [dtfw_pkg::FRAC_W-1:0]       m52;
   logic [dtfw_pkg::EXP_OUT_W-1:0]    exp_field;
   logic                              err;
   logic [dtfw_pkg::HI_MANT_W-1:0]    hi;
   logic [dtfw_pkg::WORD_W-1:0]       lo;

   assign sign = value_bits[63];
   assign ex   = value_bits[62:52];
   assign frac = value_bits[51:0];

   // The leading-zero count and the normalizing shift are built together, halving each step.
   always_comb begin
      n0    = {frac, 12'b0};
      lz[5] = (n0[63:32] == '0);
      n1    = lz[5] ? (n0 << 32) : n0;
      lz[4] = (n1[63:48] == '0);
      n2    = lz[4] ? (n1 << 16) : n1;
      lz[3] = (n2[63:56] == '0);
      n3    = lz[3] ? (n2 << 8) : n2;
      lz[2] = (n3[63:60] == '0);
      n4    = lz[2] ? (n3 << 4) : n3;
      lz[1] = (n4[63:62] == '0);
      n5    = lz[1] ? (n4 << 2) : n4;
      lz[0] = !n5[63];
      n6    = lz[0] ? (n5 << 1) : n5;
   end

   always_comb begin
      sum       = {1'b0, ex} + dtfw_pkg::EXP_NORMAL_BIAS;
      m52       = {1'b1, frac[51:1]};
      exp_field = '0;
      err       = 1'b0;
      if (ex == dtfw_pkg::EXP_IN_SPECIAL) begin
         exp_field = dtfw_pkg::EXP_FIELD_MAX;
         err       = 1'b1;
      end else if (ex == '0) begin
         m52 = n6[63:12];
         if (lz <= dtfw_pkg::SUB_LZ_LIMIT) begin
            exp_field = dtfw_pkg::EXP_OUT_W'(dtfw_pkg::SUB_LZ_LIMIT - lz);
         end else begin
            err = 1'b1;
         end
      end else if (sum[dtfw_pkg::EXP_OUT_W]) begin
         exp_field = dtfw_pkg::EXP_FIELD_MAX;
         err       = 1'b1;
      end else begin
         exp_field = sum[dtfw_pkg::EXP_OUT_W-1:0];
      end
   end

   assign hi = m52[51:32] ^ {dtfw_pkg::HI_MANT_W{sign}};
   assign lo = m52[31:0] ^ {dtfw_pkg::WORD_W{sign}};

   always_comb begin
      if (ex == '0 && frac == '0) begin
         result = '0;
      end else begin
         result.word_high   = {exp_field, sign, hi};
         result.word_low    = lo;
         result.range_error = err;
      end
   end

endmodule

// ===== rtl/core/double_to_target_float_word.sv =====
// Top level of the binary64 to target float word converter.
// Accepts one binary64 bit pattern per cycle unless stalled and delivers its target float
// word: the beat is captured in an input register, normalized by a six-step leading-zero
// shifter and registered again at the result port. Both registers stall only when the
// result beat ahead of them is not taken, so throughput is one beat per cycle. Infinity,
// NaN and exponents outside the target range set range_error with a saturated exponent.
module double_to_target_float_word (
   input  logic           clock,
   input  logic           reset,
   dtfw_req_if.sink       req_chan,
   dtfw_rsp_if.source     rsp_chan
);

   logic                           in_valid_ff;
   logic [dtfw_pkg::VALUE_W-1:0]   value_ff;
   logic                           out_valid_ff;
   dtfw_pkg::result_type           result_ff;
   dtfw_pkg::result_type           result_in;
   logic                           out_ready;
   logic                           in_ready;

   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;

   dtfw_norm u_norm (
      .value_bits (value_ff),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         value_ff <= req_chan.value_bits;
      end
      if (out_ready && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.word_high   = result_ff.word_high;
   assign rsp_chan.word_low    = result_ff.word_low;
   assign rsp_chan.range_error = result_ff.range_error;

endmodule

// ===== rtl/core/dtfw_checker.sv =====
// Port-level checker of the binary64 to target float word converter and its bind.
`include "double_to_target_float_word_defines.svh"

module dtfw_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dtfw_pkg::WORD_W-1:0]   word_high,
   input logic [dtfw_pkg::WORD_W-1:0]   word_low,
   input logic                          range_error
);

   // A stalled result beat stays offered.
   `DTFW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // With the result register empty the input side is ready for a beat.
   `DTFW_ASSERT_IMPLY(a_req_ready, clock, reset, !rsp_valid, req_ready)

   // A range error always comes with a saturated exponent field.
   `DTFW_ASSERT_IMPLY(a_err_sat, clock, reset, rsp_valid && range_error,
      word_high[31:21] == '0 || word_high[31:21] == dtfw_pkg::EXP_FIELD_MAX)

   // Every nonzero result has its leading mantissa bit opposite to the sign.
   `DTFW_ASSERT_IMPLY(a_lead_bit, clock, reset, rsp_valid && (word_high[19] == word_high[20]),
      word_high == '0 && word_low == '0 && !range_error)

endmodule

bind double_to_target_float_word dtfw_port_checker u_dtfw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .word_high   (rsp_chan.word_high),
   .word_low    (rsp_chan.word_low),
   .range_error (rsp_chan.range_error)
);
